FILE: design/epo_pkg.sv
// ----------------------------------------------------------------------------
// epo_pkg
// Shared constants and types for the edge point offset pipeline.
// ----------------------------------------------------------------------------
package epo_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int INDEX_BITS_DEF = 24;

  localparam int COORD_W = 32;
  localparam int IDX_W   = 24;
  localparam int TERM_W  = 64;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 33;
  localparam int ADDR_W  = 3;

  // Register select, taken from paddr[2]
  localparam logic REG_DISTANCE = 1'b0;
  localparam logic REG_FRACTION = 1'b1;

  localparam logic [COORD_W-1:0] FRACTION_RESET = 32'd6554;

  // Per-item data that rides along the pipeline
  typedef struct packed {
    logic [2:0][COORD_W-1:0] s;
    logic [2:0]              dn;
    logic                    zero;
    logic [2:0][TERM_W-1:0]  tf;
    logic [IDX_W-1:0]        idx;
  } carry_t;

endpackage

FILE: design/edge_point_offset.sv
// ----------------------------------------------------------------------------
// edge_point_offset
// Places one bevel point at start + fraction*(end-start) + distance*unit(edge).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes an edge start point, end point and
//   a point index. Result channel (out_valid/out_ready) returns the new point,
//   the index, a saturation flag and a zero-length-edge flag, one result for
//   every request, in order.
//   Configuration: APB-style port, offset_distance at 0x0, edge_fraction at
//   0x4. Write only while the pipeline is empty.
// Throughput: one request per cycle while the result side is not stalled.
// Depth: 74 register stages. The depth is set by the square root (one
//   result bit per stage, 32 stages) and the three parallel dividers (one
//   quotient bit per stage, 33 stages).
// Reset: pipeline valid bits clear, registers return to distance 0 and
//   fraction 6554 (about 0.1).
// Stall: when out_valid is high and out_ready low, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module edge_point_offset #(
  parameter int FRAC_BITS  = epo_pkg::FRAC_BITS_DEF,
  parameter int INDEX_BITS = epo_pkg::INDEX_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [31:0]           in_start_x,
  input  logic signed [31:0]           in_start_y,
  input  logic signed [31:0]           in_start_z,
  input  logic signed [31:0]           in_end_x,
  input  logic signed [31:0]           in_end_y,
  input  logic signed [31:0]           in_end_z,
  input  logic [23:0]                  in_point_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [31:0]           out_x,
  output logic signed [31:0]           out_y,
  output logic signed [31:0]           out_z,
  output logic [23:0]                  out_index,
  output logic                         out_saturated,
  output logic                         out_zero_edge,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [epo_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import epo_pkg::*;

  localparam logic [TERM_W-1:0] HALF = TERM_W'(1) << (FRAC_BITS - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [COORD_W-1:0] distance_r, fraction_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      distance_r <= '0;
      fraction_r <= FRACTION_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_DISTANCE: distance_r <= cfg_pwdata;
        REG_FRACTION: fraction_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_DISTANCE: cfg_prdata = distance_r;
      REG_FRACTION: cfg_prdata = fraction_r;
      default:      cfg_prdata = '0;
    endcase
  end

  logic               fneg, dneg;
  logic [COORD_W-1:0] fmag, dmag;
  assign fneg = fraction_r[COORD_W-1];
  assign dneg = distance_r[COORD_W-1];
  assign fmag = fneg ? COORD_W'(-fraction_r) : fraction_r;
  assign dmag = dneg ? COORD_W'(-distance_r) : distance_r;

  // --------------------------------------------------------------------------
  // Pipeline enable: the whole pipe advances unless the output is held
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_r;
  assign en       = ~out_valid_r | out_ready;
  assign in_ready = en;

  // --------------------------------------------------------------------------
  // Stage 1: edge vector
  // --------------------------------------------------------------------------
  logic                v1_r;
  carry_t              c1_r, c1_nxt;
  logic [2:0][32:0]    d1_r, d1_nxt;
  logic [IDX_W-1:0]    idx_mask;

  always_comb begin
    idx_mask = (INDEX_BITS >= IDX_W) ? '1 : IDX_W'((64'(1) << INDEX_BITS) - 64'(1));
    c1_nxt      = '0;
    c1_nxt.s[0] = in_start_x;
    c1_nxt.s[1] = in_start_y;
    c1_nxt.s[2] = in_start_z;
    c1_nxt.idx  = in_point_index & idx_mask;
    d1_nxt[0] = {in_end_x[31], in_end_x} - {in_start_x[31], in_start_x};
    d1_nxt[1] = {in_end_y[31], in_end_y} - {in_start_y[31], in_start_y};
    d1_nxt[2] = {in_end_z[31], in_end_z} - {in_start_z[31], in_start_z};
  end

  // --------------------------------------------------------------------------
  // Stage 2: magnitudes, signs, largest magnitude
  // --------------------------------------------------------------------------
  logic                v2_r;
  carry_t              c2_r, c2_nxt;
  logic [2:0][31:0]    dm2_r, dm2_nxt;
  logic [31:0]         maxm2_r, maxm2_nxt;

  always_comb begin
    c2_nxt = c1_r;
    for (int c = 0; c < 3; c++) begin
      c2_nxt.dn[c] = d1_r[c][32];
      dm2_nxt[c]   = d1_r[c][32] ? 32'(-d1_r[c]) : d1_r[c][31:0];
    end
    maxm2_nxt = dm2_nxt[0];
    if (dm2_nxt[1] > maxm2_nxt) maxm2_nxt = dm2_nxt[1];
    if (dm2_nxt[2] > maxm2_nxt) maxm2_nxt = dm2_nxt[2];
    c2_nxt.zero = (maxm2_nxt == '0);
  end

  // --------------------------------------------------------------------------
  // Stage 3: normalizing shift, fraction products
  // --------------------------------------------------------------------------
  logic                v3_r;
  carry_t              c3_r;
  logic [2:0][31:0]    dm3_r;
  logic [2:0][63:0]    p3_r, p3_nxt;
  logic                shr3_r, shr3_nxt;
  logic [4:0]          shl3_r, shl3_nxt;
  logic [4:0]          top_bit;

  always_comb begin
    top_bit = '0;
    for (int i = 0; i < 31; i++) begin
      if (maxm2_r[i]) top_bit = 5'(i);
    end
    shr3_nxt = maxm2_r[31];
    shl3_nxt = maxm2_r[31] ? 5'd0 : 5'd30 - top_bit;
    for (int c = 0; c < 3; c++) begin
      p3_nxt[c] = 64'(fmag) * 64'(dm2_r[c]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: fraction term, scaled components
  // --------------------------------------------------------------------------
  logic                v4_r;
  carry_t              c4_r, c4_nxt;
  logic [2:0][30:0]    sc4_r, sc4_nxt;
  logic [TERM_W-1:0]   tf_mag;
  logic [62:0]         sc_wide;

  always_comb begin
    c4_nxt = c3_r;
    tf_mag = '0;
    sc_wide = '0;
    for (int c = 0; c < 3; c++) begin
      tf_mag = (p3_r[c] + HALF) >> FRAC_BITS;
      c4_nxt.tf[c] = (fneg != c3_r.dn[c]) ? -tf_mag : tf_mag;
      sc_wide = (63'(dm3_r[c]) >> shr3_r) << shl3_r;
      sc4_nxt[c] = sc_wide[30:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: squares; stage 6: sum of squares
  // --------------------------------------------------------------------------
  logic                v5_r, v6_r;
  carry_t              c5_r, c6_r;
  logic [2:0][30:0]    sc5_r, sc6_r;
  logic [2:0][61:0]    sq5_r;
  logic [63:0]         sum6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r    <= c1_nxt;
      d1_r    <= d1_nxt;
      c2_r    <= c2_nxt;
      dm2_r   <= dm2_nxt;
      maxm2_r <= maxm2_nxt;
      c3_r    <= c2_r;
      dm3_r   <= dm2_r;
      p3_r    <= p3_nxt;
      shr3_r  <= shr3_nxt;
      shl3_r  <= shl3_nxt;
      c4_r    <= c4_nxt;
      sc4_r   <= sc4_nxt;
      c5_r    <= c4_r;
      sc5_r   <= sc4_r;
      for (int c = 0; c < 3; c++) begin
        sq5_r[c] <= 62'(sc4_r[c]) * 62'(sc4_r[c]);
      end
      c6_r    <= c5_r;
      sc6_r   <= sc5_r;
      sum6_r  <= 64'(sq5_r[0]) + 64'(sq5_r[1]) + 64'(sq5_r[2]);
    end
  end

  // --------------------------------------------------------------------------
  // Integer square root: one result bit per stage
  // --------------------------------------------------------------------------
  logic              sq_v_r   [0:SQRT_STEPS];
  carry_t            sq_c_r   [0:SQRT_STEPS];
  logic [2:0][30:0]  sq_sc_r  [0:SQRT_STEPS];
  logic [63:0]       sq_n_r   [0:SQRT_STEPS];
  logic [63:0]       sq_res_r [0:SQRT_STEPS];

  assign sq_v_r[0]   = v6_r;
  assign sq_c_r[0]   = c6_r;
  assign sq_sc_r[0]  = sc6_r;
  assign sq_n_r[0]   = sum6_r;
  assign sq_res_r[0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [63:0] trial;
    logic [63:0] n_nxt, res_nxt;

    always_comb begin
      trial = sq_res_r[k] + BIT;
      if (sq_n_r[k] >= trial) begin
        n_nxt   = sq_n_r[k] - trial;
        res_nxt = (sq_res_r[k] >> 1) + BIT;
      end else begin
        n_nxt   = sq_n_r[k];
        res_nxt = sq_res_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_c_r[k+1]   <= sq_c_r[k];
        sq_sc_r[k+1]  <= sq_sc_r[k];
        sq_n_r[k+1]   <= n_nxt;
        sq_res_r[k+1] <= res_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Offset numerators, then rounding bias
  // --------------------------------------------------------------------------
  logic              vn1_r, vn2_r;
  carry_t            cn1_r, cn2_r;
  logic [31:0]       len_n1_r, len_n2_r;
  logic [2:0][62:0]  num1_r;
  logic [2:0][63:0]  num2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn1_r <= 1'b0;
      vn2_r <= 1'b0;
    end else if (en) begin
      vn1_r <= sq_v_r[SQRT_STEPS];
      vn2_r <= vn1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cn1_r    <= sq_c_r[SQRT_STEPS];
      len_n1_r <= sq_res_r[SQRT_STEPS][31:0];
      for (int c = 0; c < 3; c++) begin
        num1_r[c] <= 63'(dmag) * 63'(sq_sc_r[SQRT_STEPS][c]);
        num2_r[c] <= 64'(num1_r[c]) + 64'(len_n1_r >> 1);
      end
      cn2_r    <= cn1_r;
      len_n2_r <= len_n1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Three restoring dividers, one quotient bit per stage
  // --------------------------------------------------------------------------
  logic              dv_v_r   [0:DIV_STEPS];
  carry_t            dv_c_r   [0:DIV_STEPS];
  logic [31:0]       dv_len_r [0:DIV_STEPS];
  logic [2:0][32:0]  dv_rem_r [0:DIV_STEPS];
  logic [2:0][32:0]  dv_low_r [0:DIV_STEPS];
  logic [2:0][32:0]  dv_q_r   [0:DIV_STEPS];

  assign dv_v_r[0]   = vn2_r;
  assign dv_c_r[0]   = cn2_r;
  assign dv_len_r[0] = len_n2_r;
  for (genvar c = 0; c < 3; c++) begin : g_div_init
    assign dv_rem_r[0][c] = {2'b00, num2_r[c][63:33]};
    assign dv_low_r[0][c] = num2_r[c][32:0];
    assign dv_q_r[0][c]   = '0;
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [2:0][32:0] rem_nxt, q_nxt;
    logic [32:0]      shifted;

    always_comb begin
      shifted = '0;
      for (int c = 0; c < 3; c++) begin
        shifted = {dv_rem_r[j][c][31:0], dv_low_r[j][c][32]};
        if (shifted >= {1'b0, dv_len_r[j]}) begin
          rem_nxt[c] = shifted - {1'b0, dv_len_r[j]};
          q_nxt[c]   = {dv_q_r[j][c][31:0], 1'b1};
        end else begin
          rem_nxt[c] = shifted;
          q_nxt[c]   = {dv_q_r[j][c][31:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_c_r[j+1]   <= dv_c_r[j];
        dv_len_r[j+1] <= dv_len_r[j];
        dv_rem_r[j+1] <= rem_nxt;
        dv_q_r[j+1]   <= q_nxt;
        for (int c = 0; c < 3; c++) begin
          dv_low_r[j+1][c] <= {dv_low_r[j][c][31:0], 1'b0};
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Final sum, saturation, output register
  // --------------------------------------------------------------------------
  carry_t                  cf;
  logic [2:0][COORD_W-1:0] res_nxt;
  logic                    sat_nxt;
  logic [TERM_W-1:0]       to_val, sum_val;
  logic [2:0][COORD_W-1:0] res_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    sat_r, zero_r;

  always_comb begin
    cf      = dv_c_r[DIV_STEPS];
    sat_nxt = 1'b0;
    to_val  = '0;
    sum_val = '0;
    for (int c = 0; c < 3; c++) begin
      to_val = TERM_W'(dv_q_r[DIV_STEPS][c]);
      if (dneg != cf.dn[c]) to_val = -to_val;
      if (cf.zero) to_val = '0;
      sum_val = TERM_W'(signed'(cf.s[c])) + cf.tf[c] + to_val;
      if ($signed(sum_val) > $signed(TERM_W'(32'sh7fffffff))) begin
        res_nxt[c] = 32'h7fffffff;
        sat_nxt    = 1'b1;
      end else if ($signed(sum_val) < -$signed(TERM_W'(64'h80000000))) begin
        res_nxt[c] = 32'h80000000;
        sat_nxt    = 1'b1;
      end else begin
        res_nxt[c] = sum_val[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r  <= res_nxt;
      idx_r  <= cf.idx;
      sat_r  <= sat_nxt;
      zero_r <= cf.zero;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x         = res_r[0];
  assign out_y         = res_r[1];
  assign out_z         = res_r[2];
  assign out_index     = idx_r;
  assign out_saturated = sat_r;
  assign out_zero_edge = zero_r;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for edge_point_offset: drives edge requests with random
// gaps, stalls the result side at random, and compares every point, index
// and flag against a bit-exact software model of the offset arithmetic.
// ----------------------------------------------------------------------------
module tb_top;
  import epo_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int DRAIN_CYCLES = 90;
  localparam int QUIET_LIMIT = 3000;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    logic signed [31:0] sx, sy, sz, ex, ey, ez;
    logic [23:0]        idx;
  } edge_req_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic [23:0]        idx;
    logic               sat, zero;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_start_x = '0, in_start_y = '0, in_start_z = '0;
  logic signed [31:0] in_end_x = '0, in_end_y = '0, in_end_z = '0;
  logic [23:0] in_point_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic [23:0] out_index;
  logic out_saturated, out_zero_edge;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // model copy of the two registers
  logic signed [31:0] distance_q = 32'sd0;
  logic signed [31:0] fraction_q = FRACTION_RESET;

  point_t expected_points[$];
  int n_sent = 0, n_checked = 0, n_errors = 0, n_cfg = 0, n_sat = 0, n_zero = 0;
  int quiet = 0;
  bit no_idle = 0;

  edge_point_offset dut (.*);

  always #HALF_PERIOD clk = ~clk;

  function automatic point_t place_point(edge_req_t r);
    longint s[3], d[3], tf[3], to[3], v;
    logic signed [31:0] e[3];
    bit [63:0] dm[3], sc[3], maxm, mm, sum, len, fmag, dmag, p, q, n, bitv, res;
    bit dn[3];
    bit fneg, dneg;
    int shr, shl;
    point_t o;
    s[0] = r.sx; s[1] = r.sy; s[2] = r.sz;
    e[0] = r.ex; e[1] = r.ey; e[2] = r.ez;
    maxm = 0;
    for (int c = 0; c < 3; c++) begin
      d[c] = longint'(e[c]) - s[c];
      dn[c] = d[c] < 0;
      dm[c] = dn[c] ? 64'(-d[c]) : 64'(d[c]);
      if (dm[c] > maxm) maxm = dm[c];
      tf[c] = 0;
      to[c] = 0;
    end
    o.zero = (maxm == 0);
    if (!o.zero) begin
      fneg = fraction_q < 0;
      dneg = distance_q < 0;
      fmag = fneg ? 64'(-longint'(fraction_q)) : 64'(longint'(fraction_q));
      dmag = dneg ? 64'(-longint'(distance_q)) : 64'(longint'(distance_q));
      for (int c = 0; c < 3; c++) begin
        p = fmag * dm[c];
        tf[c] = longint'((p + (64'd1 << (FRAC_BITS_DEF - 1))) >> FRAC_BITS_DEF);
        if (fneg != dn[c]) tf[c] = -tf[c];
      end
      // normalize so the largest component sits in [2^30, 2^31)
      mm = maxm;
      shr = 0;
      shl = 0;
      if (mm >= (64'd1 << 31)) begin
        shr = 1;
        mm >>= 1;
      end
      while (mm < (64'd1 << 30)) begin
        mm <<= 1;
        shl++;
      end
      sum = 0;
      for (int c = 0; c < 3; c++) begin
        sc[c] = (dm[c] >> shr) << shl;
        sum += sc[c] * sc[c];
      end
      // floor square root, digit by digit
      n = sum;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      len = res;
      for (int c = 0; c < 3; c++) begin
        q = (dmag * sc[c] + (len >> 1)) / len;
        to[c] = longint'(q);
        if (dneg != dn[c]) to[c] = -to[c];
      end
    end
    o.sat = 0;
    for (int c = 0; c < 3; c++) begin
      v = s[c] + tf[c] + to[c];
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
        o.sat = 1;
      end else if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
        o.sat = 1;
      end
      if (c == 0) o.x = v[31:0];
      else if (c == 1) o.y = v[31:0];
      else o.z = v[31:0];
    end
    o.idx = r.idx;
    return o;
  endfunction

  task automatic send_edge(edge_req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_x <= r.sx; in_start_y <= r.sy; in_start_z <= r.sz;
    in_end_x <= r.ex; in_end_y <= r.ey; in_end_z <= r.ez;
    in_point_index <= r.idx;
    do @(posedge clk); while (!in_ready);
    expected_points.insert(expected_points.size(), place_point(r));
    n_sent++;
  endtask

  // drop valid and let the pipeline empty out
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic sel, logic [31:0] value);
    drain_pipeline();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {sel, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (sel == REG_DISTANCE) distance_q = value;
    else fraction_q = value;
    n_cfg++;
  endtask

  function automatic edge_req_t make_edge(logic signed [31:0] sx, sy, sz, ex, ey, ez,
                                          logic [23:0] idx);
    edge_req_t r;
    r.sx = sx; r.sy = sy; r.sz = sz;
    r.ex = ex; r.ey = ey; r.ez = ez;
    r.idx = idx;
    return r;
  endfunction

  function automatic edge_req_t random_edge();
    edge_req_t r;
    int kind;
    logic signed [31:0] span;
    kind = $urandom_range(0, 9);
    r.idx = 24'($urandom);
    r.sx = $urandom; r.sy = $urandom; r.sz = $urandom;
    if (kind < 5) begin
      // short edge near a random origin, magnitude of the span random
      span = 32'sd1 <<< $urandom_range(0, 30);
      r.sx = $signed($urandom) >>> 2;
      r.sy = $signed($urandom) >>> 2;
      r.sz = $signed($urandom) >>> 2;
      r.ex = r.sx + ($signed($urandom) % span);
      r.ey = r.sy + ($signed($urandom) % span);
      r.ez = r.sz + ($signed($urandom) % span);
    end else if (kind == 5) begin
      r.ex = r.sx; r.ey = r.sy; r.ez = r.sz;
    end else if (kind == 6) begin
      // single axis edge
      r.ex = r.sx; r.ey = r.sy; r.ez = r.sz;
      case ($urandom_range(0, 2))
        0: r.ex = $urandom;
        1: r.ey = $urandom;
        default: r.ez = $urandom;
      endcase
    end else begin
      r.ex = $urandom; r.ey = $urandom; r.ez = $urandom;
    end
    return r;
  endfunction

  task automatic test_reset_defaults();
    send_edge(make_edge(0, 0, 0, 32'sh0001_0000, 0, 0, 24'h000001));
    send_edge(make_edge(32'sh0010_0000, -32'sh0010_0000, 7, 32'sh0010_0000,
                        -32'sh0010_0000, 7, 24'hFFFFFF));
    send_edge(make_edge(-100, 200, -300, 400, -500, 600, 24'h000000));
    drain_pipeline();
  endtask

  task automatic test_directed();
    write_reg(REG_DISTANCE, 32'sh0002_0000);
    write_reg(REG_FRACTION, 32'sh0000_8000);
    send_edge(make_edge(0, 0, 0, 0, 0, 0, 24'h123456));
    send_edge(make_edge(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                        32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'hFFFFFF));
    send_edge(make_edge(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                        32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 24'h000000));
    send_edge(make_edge(0, 0, 0, 1, 0, 0, 24'hAAAAAA));
    send_edge(make_edge(0, 0, 0, 0, -1, 0, 24'h555555));
    send_edge(make_edge(5, 5, 5, 5, 5, 6, 24'h000001));
    send_edge(make_edge(32'sh7FFF_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0, 24'h800000));
    send_edge(make_edge(-3, 4, 0, 3, -4, 0, 24'h0F0F0F));
    write_reg(REG_FRACTION, 32'sh7FFF_FFFF);
    write_reg(REG_DISTANCE, 32'sh8000_0000);
    send_edge(make_edge(0, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 0, 24'h000010));
    send_edge(make_edge(32'sh8000_0000, 0, 0, 32'sh8000_0000, 0, 0, 24'h000011));
    send_edge(make_edge(-2, -2, -2, 2, 2, 2, 24'h000012));
    write_reg(REG_FRACTION, 32'sh8000_0000);
    write_reg(REG_DISTANCE, 32'sh7FFF_FFFF);
    send_edge(make_edge(0, 0, 0, -32'sh0000_1000, 32'sh0000_2000, 0, 24'h000013));
    send_edge(make_edge(32'sh4000_0000, 0, 0, 32'sh4000_0001, 0, 0, 24'h000014));
    write_reg(REG_FRACTION, 32'sh0000_0000);
    write_reg(REG_DISTANCE, 32'shFFFF_FFFF);
    send_edge(make_edge(10, 20, 30, 11, 20, 30, 24'h000015));
    send_edge(make_edge(0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 24'h000016));
    drain_pipeline();
  endtask

  task automatic test_random_sweep(int items);
    for (int i = 0; i < items; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: write_reg(REG_FRACTION, $urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
          1: write_reg(REG_FRACTION, $urandom);
          default: write_reg(REG_FRACTION, $urandom_range(0, 32'h0001_0000));
        endcase
        if ($urandom_range(0, 3) == 0) write_reg(REG_DISTANCE, $urandom);
        else write_reg(REG_DISTANCE, $signed($urandom) >>> $urandom_range(4, 16));
        no_idle = ($urandom_range(0, 3) == 0);
      end
      send_edge(random_edge());
    end
    no_idle = 0;
    drain_pipeline();
  endtask

  // sender holds off until every result is back, then bursts
  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) send_edge(random_edge());
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    no_idle = 1;
    for (int i = 0; i < 20; i++) send_edge(random_edge());
    no_idle = 0;
    drain_pipeline();
  endtask

  // result side: random stall before each result, none in no-idle stretches
  initial begin
    int hold;
    @(posedge clk iff rst_n);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN) $display("unexpected result index %h", out_index);
      end else begin
        want = expected_points.pop_front();
        n_checked++;
        if (want.sat) n_sat++;
        if (want.zero) n_zero++;
        if (out_x !== want.x || out_y !== want.y || out_z !== want.z ||
            out_index !== want.idx || out_saturated !== want.sat ||
            out_zero_edge !== want.zero) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("mismatch: want %h %h %h idx %h s%b z%b, got %h %h %h idx %h s%b z%b",
                     want.x, want.y, want.z, want.idx, want.sat, want.zero,
                     out_x, out_y, out_z, out_index, out_saturated, out_zero_edge);
        end
      end
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_drain_pause();
    test_random_sweep(640);
    if (expected_points.size() != 0) n_errors++;
    $display("sent %0d edges, checked %0d points (%0d saturated, %0d zero-length)",
             n_sent, n_checked, n_sat, n_zero);
    $display("%0d register writes, %0d failures", n_cfg, n_errors);
    if (n_errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
